// ===== hdl/mandelbrot_escape_time_pixel_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the escape-time pixel unit
// Shared property forms, clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef MANDELBROT_ESCAPE_TIME_PIXEL_UNIT_DEFINES_SVH
`define MANDELBROT_ESCAPE_TIME_PIXEL_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent
`define MBE_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define MBE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/mbe_pkg.sv =====
// ----------------------------------------------------------------------------
// mbe_pkg
// Types and fixed widths shared by the escape-time pixel unit.
// ----------------------------------------------------------------------------
package mbe_pkg;

    localparam int FRAC_BITS = 28;   // Q.28 coordinates
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 3;
    localparam int ORIGIN_W  = 32;
    localparam int STEP_W    = 31;
    localparam int RAD_W     = 31;
    localparam int ITER_W    = 8;
    localparam int PIX_W     = 12;
    localparam int IDX_MAX_W = 16;   // widest pixel index the unit supports
    localparam int Z_W       = 50;   // c and z, signed, never overflows
    localparam int MUL_W     = 33;   // shared multiplier operand width
    localparam int PROD_W    = 2 * MUL_W;
    localparam int SQ_W      = 62;   // square of a value below 2^31

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ORIGIN_RE = 3'd0,
        REG_ORIGIN_IM = 3'd1,
        REG_STEP_RE   = 3'd2,
        REG_STEP_IM   = 3'd3,
        REG_RADIUS    = 3'd4,
        REG_MAX_ITER  = 3'd5
    } cfg_reg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CRE,
        ST_CIM,
        ST_TSQ,
        ST_CHECK,
        ST_MRR,
        ST_MII,
        ST_MRI,
        ST_UPD,
        ST_DONE
    } state_t;

    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_CRE,
        MUL_CIM,
        MUL_TSQ,
        MUL_RR,
        MUL_II,
        MUL_RI
    } mul_op_t;

    typedef struct packed {
        mul_op_t op;
        logic    start;
        logic    step;
        logic    finish;
    } ctrl_t;

    typedef struct packed {
        logic escape_abs;
        logic limit_hit;
        logic mag_inside;
    } status_t;

endpackage

// ===== hdl/mbe_mul.sv =====
// ----------------------------------------------------------------------------
// mbe_mul
// Shared signed multiplier used for the centre, radius and z products.
// ----------------------------------------------------------------------------
module mbe_mul
(
    input  logic signed [mbe_pkg::MUL_W-1:0]  a,
    input  logic signed [mbe_pkg::MUL_W-1:0]  b,
    output logic signed [mbe_pkg::PROD_W-1:0] p
);

    assign p = mbe_pkg::PROD_W'(a) * mbe_pkg::PROD_W'(b);

endmodule

// ===== hdl/mbe_dp.sv =====
// ----------------------------------------------------------------------------
// mbe_dp
// Datapath: pixel centre, z registers, product registers and step count.
// ----------------------------------------------------------------------------
module mbe_dp
#(
    parameter int COORD_BITS = 12
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  mbe_pkg::ctrl_t                     ctrl,
    input  logic [mbe_pkg::PIX_W-1:0]          pixel_col,
    input  logic [mbe_pkg::PIX_W-1:0]          pixel_row,
    input  logic signed [mbe_pkg::ORIGIN_W-1:0] origin_re,
    input  logic signed [mbe_pkg::ORIGIN_W-1:0] origin_im,
    input  logic [mbe_pkg::STEP_W-1:0]         step_re,
    input  logic [mbe_pkg::STEP_W-1:0]         step_im,
    input  logic [mbe_pkg::RAD_W-1:0]          escape_radius,
    input  logic [mbe_pkg::ITER_W-1:0]         max_iterations,
    output mbe_pkg::status_t                   status,
    output logic [mbe_pkg::ITER_W-1:0]         count
);

    localparam int ZW = mbe_pkg::Z_W;
    localparam int MW = mbe_pkg::MUL_W;
    localparam int SW = mbe_pkg::SQ_W;

    logic [mbe_pkg::IDX_MAX_W-1:0] col_ext;
    logic [mbe_pkg::IDX_MAX_W-1:0] row_ext;
    logic [COORD_BITS-1:0]         col_reg;
    logic [COORD_BITS-1:0]         row_reg;

    logic signed [ZW-1:0] cr_reg;
    logic signed [ZW-1:0] ci_reg;
    logic signed [ZW-1:0] zr_reg;
    logic signed [ZW-1:0] zi_reg;
    logic [SW-1:0]        tt_reg;
    logic [SW-1:0]        rr_reg;
    logic [SW-1:0]        ii_reg;
    logic signed [SW:0]   ri_reg;
    logic [mbe_pkg::ITER_W-1:0] count_reg;
    logic [mbe_pkg::ITER_W-1:0] count_next;

    logic signed [MW-1:0]             mul_a;
    logic signed [MW-1:0]             mul_b;
    logic signed [mbe_pkg::PROD_W-1:0] prod;

    logic signed [ZW-1:0] centre;
    logic signed [mbe_pkg::ORIGIN_W-1:0] origin_sel;
    logic signed [SW+1:0] sq_diff;
    logic signed [SW+1:0] sq_sh;
    logic signed [SW+1:0] cross_prod;
    logic signed [SW+1:0] cross_sh;
    logic signed [ZW-1:0] zr_upd;
    logic signed [ZW-1:0] zi_upd;
    logic [SW:0]          mag_sum;
    logic [ZW-1:0]        zr_abs;
    logic [ZW-1:0]        zi_abs;
    logic [ZW-1:0]        radius_ext;

    assign col_ext = mbe_pkg::IDX_MAX_W'(pixel_col);
    assign row_ext = mbe_pkg::IDX_MAX_W'(pixel_row);

    // operand select for the shared multiplier
    always_comb
    begin
        unique case (ctrl.op)
            mbe_pkg::MUL_CRE:
            begin
                mul_a = signed'({{(MW-COORD_BITS-1){1'b0}}, col_reg, 1'b1});
                mul_b = signed'({{(MW-mbe_pkg::STEP_W){1'b0}}, step_re});
            end
            mbe_pkg::MUL_CIM:
            begin
                mul_a = signed'({{(MW-COORD_BITS-1){1'b0}}, row_reg, 1'b1});
                mul_b = signed'({{(MW-mbe_pkg::STEP_W){1'b0}}, step_im});
            end
            mbe_pkg::MUL_TSQ:
            begin
                mul_a = signed'({{(MW-mbe_pkg::RAD_W){1'b0}}, escape_radius});
                mul_b = signed'({{(MW-mbe_pkg::RAD_W){1'b0}}, escape_radius});
            end
            mbe_pkg::MUL_RR:
            begin
                mul_a = zr_reg[MW-1:0];
                mul_b = zr_reg[MW-1:0];
            end
            mbe_pkg::MUL_II:
            begin
                mul_a = zi_reg[MW-1:0];
                mul_b = zi_reg[MW-1:0];
            end
            mbe_pkg::MUL_RI:
            begin
                mul_a = zr_reg[MW-1:0];
                mul_b = zi_reg[MW-1:0];
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    mbe_mul u_mul
    (
        .a (mul_a),
        .b (mul_b),
        .p (prod)
    );

    // (2*index + 1) * step is non-negative; halve by dropping the low bit
    assign origin_sel = (ctrl.op == mbe_pkg::MUL_CIM) ? origin_im : origin_re;
    assign centre     = ZW'(origin_sel) + signed'({1'b0, prod[ZW-2:0] >> 1});

    // z update with floor shifts back to Q.28
    assign sq_diff    = signed'({2'b00, rr_reg}) - signed'({2'b00, ii_reg});
    assign sq_sh      = sq_diff >>> mbe_pkg::FRAC_BITS;
    assign cross_prod = signed'({ri_reg, 1'b0});
    assign cross_sh   = cross_prod >>> mbe_pkg::FRAC_BITS;
    assign zr_upd     = signed'(sq_sh[ZW-1:0]) + cr_reg;
    assign zi_upd     = signed'(cross_sh[ZW-1:0]) + ci_reg;

    assign mag_sum    = {1'b0, rr_reg} + {1'b0, ii_reg};
    assign zr_abs     = zr_reg[ZW-1] ? unsigned'(-zr_reg) : unsigned'(zr_reg);
    assign zi_abs     = zi_reg[ZW-1] ? unsigned'(-zi_reg) : unsigned'(zi_reg);
    assign radius_ext = {{(ZW-mbe_pkg::RAD_W){1'b0}}, escape_radius};

    assign status.escape_abs = (zr_abs >= radius_ext) || (zi_abs >= radius_ext);
    assign status.limit_hit  = (count_reg >= max_iterations);
    assign status.mag_inside = (mag_sum < {1'b0, tt_reg});

    always_comb
    begin
        priority if (ctrl.start)
            count_next = '0;
        else if (ctrl.step)
            count_next = count_reg + 1'b1;
        else
            count_next = count_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            col_reg <= col_ext[COORD_BITS-1:0];
            row_reg <= row_ext[COORD_BITS-1:0];
        end
        if (ctrl.op == mbe_pkg::MUL_CRE)
        begin
            cr_reg <= centre;
            zr_reg <= centre;
        end
        if (ctrl.op == mbe_pkg::MUL_CIM)
        begin
            ci_reg <= centre;
            zi_reg <= centre;
        end
        if (ctrl.op == mbe_pkg::MUL_TSQ)
            tt_reg <= prod[SW-1:0];
        if (ctrl.op == mbe_pkg::MUL_RR)
            rr_reg <= prod[SW-1:0];
        if (ctrl.op == mbe_pkg::MUL_II)
            ii_reg <= prod[SW-1:0];
        if (ctrl.op == mbe_pkg::MUL_RI)
            ri_reg <= prod[SW:0];
        if (ctrl.step)
        begin
            zr_reg <= zr_upd;
            zi_reg <= zi_upd;
        end
    end

    assign count = count_reg;

endmodule

// ===== hdl/mbe_ctrl.sv =====
// ----------------------------------------------------------------------------
// mbe_ctrl
// Sequencer: schedules the shared multiplier and the escape tests per pixel.
// ----------------------------------------------------------------------------
`include "mandelbrot_escape_time_pixel_unit_defines.svh"

module mbe_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             out_free,
    input  mbe_pkg::status_t status,
    output mbe_pkg::ctrl_t   ctrl,
    output logic             busy
);

    mbe_pkg::state_t state_reg;
    mbe_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= mbe_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        unique case (state_reg)
            mbe_pkg::ST_IDLE:  state_next = in_valid ? mbe_pkg::ST_CRE : mbe_pkg::ST_IDLE;
            mbe_pkg::ST_CRE:   state_next = mbe_pkg::ST_CIM;
            mbe_pkg::ST_CIM:   state_next = mbe_pkg::ST_TSQ;
            mbe_pkg::ST_TSQ:   state_next = mbe_pkg::ST_CHECK;
            mbe_pkg::ST_CHECK:
                // limit first, then the cheap per-component radius test
                state_next = (status.limit_hit || status.escape_abs) ?
                             mbe_pkg::ST_DONE : mbe_pkg::ST_MRR;
            mbe_pkg::ST_MRR:   state_next = mbe_pkg::ST_MII;
            mbe_pkg::ST_MII:   state_next = mbe_pkg::ST_MRI;
            mbe_pkg::ST_MRI:   state_next = mbe_pkg::ST_UPD;
            mbe_pkg::ST_UPD:
                state_next = status.mag_inside ? mbe_pkg::ST_CHECK : mbe_pkg::ST_DONE;
            mbe_pkg::ST_DONE:  state_next = out_free ? mbe_pkg::ST_IDLE : mbe_pkg::ST_DONE;
            default:           state_next = mbe_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        ctrl.op     = mbe_pkg::MUL_NONE;
        ctrl.start  = 1'b0;
        ctrl.step   = 1'b0;
        ctrl.finish = 1'b0;
        unique case (state_reg)
            mbe_pkg::ST_IDLE:  ctrl.start  = in_valid;
            mbe_pkg::ST_CRE:   ctrl.op     = mbe_pkg::MUL_CRE;
            mbe_pkg::ST_CIM:   ctrl.op     = mbe_pkg::MUL_CIM;
            mbe_pkg::ST_TSQ:   ctrl.op     = mbe_pkg::MUL_TSQ;
            mbe_pkg::ST_CHECK: ctrl.op     = mbe_pkg::MUL_NONE;
            mbe_pkg::ST_MRR:   ctrl.op     = mbe_pkg::MUL_RR;
            mbe_pkg::ST_MII:   ctrl.op     = mbe_pkg::MUL_II;
            mbe_pkg::ST_MRI:   ctrl.op     = mbe_pkg::MUL_RI;
            mbe_pkg::ST_UPD:   ctrl.step   = status.mag_inside;
            mbe_pkg::ST_DONE:  ctrl.finish = out_free;
            default:           ctrl.op     = mbe_pkg::MUL_NONE;
        endcase
    end

    assign busy = (state_reg != mbe_pkg::ST_IDLE);

    `MBE_ASSERT_SAME(a_one_cmd, 1'b1, $onehot0({ctrl.start, ctrl.step, ctrl.finish}), "overlapping sequencer commands")
    `MBE_ASSERT_SAME(a_step_no_mul, ctrl.step, ctrl.op == mbe_pkg::MUL_NONE, "z update while multiplier in use")

endmodule

// ===== hdl/mandelbrot_escape_time_pixel_unit.sv =====
// The count ends on the step limit, the per-axis radius test or the squared
// magnitude test; it is the number of steps done, at most max_iterations.
// Throughput: one pixel at a time, next request taken in the cycle after the result
// is registered; each step forms three products on the shared 33x33 multiplier.
// Reset: asynchronous, active low; configuration registers to defaults, output valid cleared, sequencer idle.
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_pixel_unit
// Escape-time count for one pixel, with configuration registers and output
// register.
// ----------------------------------------------------------------------------
`include "mandelbrot_escape_time_pixel_unit_defines.svh"

module mandelbrot_escape_time_pixel_unit
#(
    parameter int COORD_BITS = 12
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [mbe_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [mbe_pkg::CFG_W-1:0]        cfg_data,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [mbe_pkg::PIX_W-1:0]        pixel_col,
    input  logic [mbe_pkg::PIX_W-1:0]        pixel_row,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [mbe_pkg::ITER_W-1:0]       iterations
);

    logic signed [mbe_pkg::ORIGIN_W-1:0] origin_re_reg;
    logic signed [mbe_pkg::ORIGIN_W-1:0] origin_im_reg;
    logic [mbe_pkg::STEP_W-1:0]          step_re_reg;
    logic [mbe_pkg::STEP_W-1:0]          step_im_reg;
    logic [mbe_pkg::RAD_W-1:0]           radius_reg;
    logic [mbe_pkg::ITER_W-1:0]          max_iter_reg;

    logic                       out_valid_reg;
    logic [mbe_pkg::ITER_W-1:0] iterations_reg;
    logic                       out_free;
    logic                       busy;
    logic [mbe_pkg::ITER_W-1:0] count;
    mbe_pkg::ctrl_t             ctrl;
    mbe_pkg::status_t           status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_re_reg <= 32'shE000_0000;
            origin_im_reg <= 32'shE800_0000;
            step_re_reg   <= 31'h0004_0000;
            step_im_reg   <= 31'h0004_0000;
            radius_reg    <= 31'h2000_0000;
            max_iter_reg  <= 8'hFF;
        end
        else if (cfg_write)
        begin
            // writes beyond the register list are dropped
            unique case (cfg_index)
                mbe_pkg::REG_ORIGIN_RE: origin_re_reg <= signed'(cfg_data);
                mbe_pkg::REG_ORIGIN_IM: origin_im_reg <= signed'(cfg_data);
                mbe_pkg::REG_STEP_RE:   step_re_reg   <= cfg_data[mbe_pkg::STEP_W-1:0];
                mbe_pkg::REG_STEP_IM:   step_im_reg   <= cfg_data[mbe_pkg::STEP_W-1:0];
                mbe_pkg::REG_RADIUS:    radius_reg    <= cfg_data[mbe_pkg::RAD_W-1:0];
                mbe_pkg::REG_MAX_ITER:  max_iter_reg  <= cfg_data[mbe_pkg::ITER_W-1:0];
                default:                max_iter_reg  <= max_iter_reg;
            endcase
        end
    end

    assign out_free = !out_valid_reg || !out_stall;

    mbe_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .out_free (out_free),
        .status   (status),
        .ctrl     (ctrl),
        .busy     (busy)
    );

    mbe_dp #(
        .COORD_BITS (COORD_BITS)
    ) u_dp
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctrl           (ctrl),
        .pixel_col      (pixel_col),
        .pixel_row      (pixel_row),
        .origin_re      (origin_re_reg),
        .origin_im      (origin_im_reg),
        .step_re        (step_re_reg),
        .step_im        (step_im_reg),
        .escape_radius  (radius_reg),
        .max_iterations (max_iter_reg),
        .status         (status),
        .count          (count)
    );

    // hold the result until taken; the sequencer waits for a free slot
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (ctrl.finish)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.finish)
            iterations_reg <= count;
    end

    assign in_stall   = busy;
    assign out_valid  = out_valid_reg;
    assign iterations = iterations_reg;

    `MBE_ASSERT_NEXT(a_busy_after_req, in_valid && !in_stall, in_stall, "request accepted but unit not busy")
    `MBE_ASSERT_NEXT(a_result_shown, ctrl.finish, out_valid_reg, "finished pixel not presented")

endmodule

// ===== test/mandelbrot_escape_time_pixel_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_pixel_checker
// Watches the configuration port and the request and result channels of the pixel
// unit, works out the escape count of every accepted pixel request and
// compares it with the count that the unit returns, in request order.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time_pixel_checker
#(
    parameter int COORD_BITS = 12
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [mbe_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [mbe_pkg::CFG_W-1:0]        cfg_data,
    input  logic                             in_valid,
    input  logic                             in_stall,
    input  logic [mbe_pkg::PIX_W-1:0]        pixel_col,
    input  logic [mbe_pkg::PIX_W-1:0]        pixel_row,
    input  logic                             out_valid,
    input  logic                             out_stall,
    input  logic [mbe_pkg::ITER_W-1:0]       iterations,
    output int                               fail_count,
    output int                               pending
);

    import mbe_pkg::*;

    typedef struct {
        logic [PIX_W-1:0]  col;
        logic [PIX_W-1:0]  row;
        logic [ITER_W-1:0] count;
    } escape_result_t;

    escape_result_t escape_q[$];
    escape_result_t fresh_req;
    escape_result_t oldest_req;
    int             mismatches;

    // Local copy of the register file
    longint         origin_re_q;
    longint         origin_im_q;
    longint         step_re_q;
    longint         step_im_q;
    longint         radius_q;
    int unsigned    max_iter_q;

    // Squared magnitude test, with a cheap per-axis escape first
    function automatic bit in_bounds(longint zr, longint zi);
        longint      ar;
        longint      ai;
        logic [63:0] mag;
        logic [63:0] lim;
        ar = (zr < 0) ? -zr : zr;
        ai = (zi < 0) ? -zi : zi;
        if (ar >= radius_q || ai >= radius_q)
            return 1'b0;
        mag = 64'(zr * zr) + 64'(zi * zi);
        lim = 64'(radius_q * radius_q);
        return mag < lim;
    endfunction

    // origin + (index + 0.5) * step, halved with floor
    function automatic longint pixel_centre(longint origin, logic [PIX_W-1:0] index,
                                            longint step);
        longint idx;
        idx = longint'(index) & ((longint'(1) << COORD_BITS) - 1);
        return origin + (((2 * idx + 1) * step) >>> 1);
    endfunction

    function automatic logic [ITER_W-1:0] escape_count(logic [PIX_W-1:0] col,
                                                       logic [PIX_W-1:0] row);
        longint      cr;
        longint      ci;
        longint      zr;
        longint      zi;
        longint      sq;
        longint      cross_prod;
        int unsigned n;
        cr = pixel_centre(origin_re_q, col, step_re_q);
        ci = pixel_centre(origin_im_q, row, step_im_q);
        zr = cr;
        zi = ci;
        n  = 0;
        while (n < max_iter_q && in_bounds(zr, zi))
        begin
            sq         = zr * zr - zi * zi;
            cross_prod = 2 * zr * zi;
            zr         = (sq >>> FRAC_BITS) + cr;
            zi         = (cross_prod >>> FRAC_BITS) + ci;
            n++;
        end
        return ITER_W'(n);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_re_q = -536870912;
            origin_im_q = -402653184;
            step_re_q   = 262144;
            step_im_q   = 262144;
            radius_q    = 536870912;
            max_iter_q  = 255;
            escape_q.delete();
            mismatches  = 0;
            fail_count <= 0;
            pending    <= 0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_ORIGIN_RE: origin_re_q = longint'(signed'(cfg_data));
                    REG_ORIGIN_IM: origin_im_q = longint'(signed'(cfg_data));
                    REG_STEP_RE:   step_re_q   = longint'(cfg_data[STEP_W-1:0]);
                    REG_STEP_IM:   step_im_q   = longint'(cfg_data[STEP_W-1:0]);
                    REG_RADIUS:    radius_q    = longint'(cfg_data[RAD_W-1:0]);
                    REG_MAX_ITER:  max_iter_q  = cfg_data[ITER_W-1:0];
                    default: ;
                endcase
            end

            if (in_valid && !in_stall)
            begin
                fresh_req.col   = pixel_col;
                fresh_req.row   = pixel_row;
                fresh_req.count = escape_count(pixel_col, pixel_row);
                escape_q.push_back(fresh_req);
            end

            if (out_valid && !out_stall)
            begin
                if (escape_q.size() == 0)
                begin
                    $display("%0t: result with no request waiting: expected none, actual %0d",
                             $time, iterations);
                    mismatches++;
                end
                else
                begin
                    oldest_req = escape_q.pop_front();
                    if (iterations !== oldest_req.count)
                    begin
                        $display("%0t: iterations for pixel (%0d, %0d): expected %0d, actual %0d",
                                 $time, oldest_req.col, oldest_req.row,
                                 oldest_req.count, iterations);
                        mismatches++;
                    end
                end
            end

            fail_count <= mismatches;
            pending    <= escape_q.size();
        end
    end

endmodule

// ===== test/tb_mandelbrot_escape_time_pixel_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_mandelbrot_escape_time_pixel_unit
// Sends pixel requests to the escape-time unit under a run of register
// settings, directed corner points first and random views after, with random
// gaps on the request side and random stalls on the result side.
// ----------------------------------------------------------------------------
module tb_mandelbrot_escape_time_pixel_unit;

    import mbe_pkg::*;

    localparam int COORD_BITS     = 12;
    localparam int ONE            = 268435456;     // 1.0 in Q4.28
    localparam int DEFAULT_IM     = -402653184;
    localparam int DEFAULT_STEP   = 262144;
    localparam int RANDOM_PHASES  = 12;
    localparam int PHASE_REQUESTS = 100;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd6;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_write;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    logic                 in_valid;
    logic                 in_stall;
    logic [PIX_W-1:0]     pixel_col;
    logic [PIX_W-1:0]     pixel_row;
    logic                 out_valid;
    logic                 out_stall;
    logic [ITER_W-1:0]    iterations;
    int                   fail_count;
    int                   pending;
    bit                   calm;
    int unsigned          run_len;
    int unsigned          hold_len;

    mandelbrot_escape_time_pixel_unit #(.COORD_BITS(COORD_BITS)) u_dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .pixel_col  (pixel_col),
        .pixel_row  (pixel_row),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .iterations (iterations)
    );

    mandelbrot_escape_time_pixel_checker #(.COORD_BITS(COORD_BITS)) u_checker
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .pixel_col  (pixel_col),
        .pixel_row  (pixel_row),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .iterations (iterations),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Mostly short gaps, now and then a long one
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (calm)
            return 0;
        else if (r < 45)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    function automatic logic [PIX_W-1:0] pick_index();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 6)
            return '0;
        else if (r < 12)
            return '1;
        else
            return PIX_W'($urandom);
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    // Drop valid, then hold until every request has come back
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Unused upper bits of the narrow registers carry noise
    task automatic set_view(input int ore, input int oim, input int sre, input int sim,
                            input int rad, input int mit);
        wait_idle();
        write_reg(REG_ORIGIN_RE, ore);
        write_reg(REG_ORIGIN_IM, oim);
        write_reg(REG_STEP_RE, {1'($urandom_range(0, 1)), sre[30:0]});
        write_reg(REG_STEP_IM, {1'($urandom_range(0, 1)), sim[30:0]});
        write_reg(REG_RADIUS, {1'($urandom_range(0, 1)), rad[30:0]});
        write_reg(REG_MAX_ITER, {24'($urandom), mit[7:0]});
        if ($urandom_range(0, 3) == 0)
            write_reg(REG_SPARE, $urandom);
    endtask

    task automatic send_pixel(input logic [PIX_W-1:0] col, input logic [PIX_W-1:0] row);
        int unsigned gap;
        in_valid  <= 1'b1;
        pixel_col <= col;
        pixel_row <= row;
        do
            @(posedge clk);
        while (in_stall);
        gap = pick_gap();
        if (gap != 0)
        begin
            in_valid  <= 1'b0;
            pixel_col <= PIX_W'($urandom);
            pixel_row <= PIX_W'($urandom);
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic random_view(input int kind);
        int ore;
        int oim;
        int sre;
        int sim;
        int rad;
        int mit;
        ore = -2 * ONE + int'($urandom_range(0, ONE / 2)) - ONE / 4;
        oim = DEFAULT_IM + int'($urandom_range(0, ONE / 2)) - ONE / 4;
        sre = DEFAULT_STEP >> $urandom_range(0, 2);
        sim = DEFAULT_STEP >> $urandom_range(0, 2);
        rad = 2 * ONE;
        mit = $urandom_range(1, 64);
        case (kind)
            1:
            begin
                // anywhere, any scale
                ore = $urandom;
                oim = $urandom;
                sre = ($urandom & 32'h7FFF_FFFF) >> $urandom_range(0, 31);
                sim = ($urandom & 32'h7FFF_FFFF) >> $urandom_range(0, 31);
                rad = $urandom_range(0, 4 * ONE);
                mit = $urandom_range(0, 255);
            end
            2:
            begin
                // close zoom on the set boundary
                ore = -201326592 + int'($urandom_range(0, 1 << 20));
                oim = 26843546 + int'($urandom_range(0, 1 << 20));
                sre = $urandom_range(1, 4096);
                sim = $urandom_range(1, 4096);
                mit = $urandom_range(96, 255);
            end
            3:
            begin
                case ($urandom_range(0, 2))
                    0:       rad = 32'h7FFF_FFFF;
                    1:       rad = 4 * ONE;
                    default: rad = $urandom_range(4 * ONE, 32'h7FFF_FFFF);
                endcase
                mit = $urandom_range(1, 128);
            end
            4:
            begin
                ore = int'($urandom_range(0, 4 * ONE)) - 2 * ONE;
                oim = int'($urandom_range(0, 4 * ONE)) - 2 * ONE;
                sre = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 0;
                sim = $urandom_range(0, 1) ? 0 : $urandom_range(0, 1 << 20);
                mit = $urandom_range(0, 255);
            end
            5:
            begin
                case ($urandom_range(0, 2))
                    0:       mit = 255;
                    1:       mit = 0;
                    default: rad = 0;
                endcase
            end
            default: ;
        endcase
        set_view(ore, oim, sre, sim, rad, mit);
    endtask

    initial
    begin
        rst_n     = 1'b0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        in_valid  = 1'b0;
        pixel_col = '0;
        pixel_row = '0;
        calm      = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Register defaults: corners, point outside radius, points deep inside
        send_pixel(0, 0);
        send_pixel(4095, 4095);
        send_pixel(1536, 1536);
        send_pixel(2048, 1536);
        send_pixel(4095, 0);
        send_pixel(0, 4095);

        // zero iteration limit
        set_view(-2 * ONE, DEFAULT_IM, DEFAULT_STEP, DEFAULT_STEP, 2 * ONE, 0);
        send_pixel(1536, 1536);
        send_pixel(2048, 1536);

        // zero radius
        set_view(-2 * ONE, DEFAULT_IM, DEFAULT_STEP, DEFAULT_STEP, 0, 200);
        send_pixel(1536, 1536);

        // radius beyond its nominal range
        set_view(-2 * ONE, DEFAULT_IM, DEFAULT_STEP, DEFAULT_STEP, 32'h7FFF_FFFF, 255);
        send_pixel(1536, 1536);
        send_pixel(0, 0);
        send_pixel(4095, 4095);

        // origin and step extremes
        set_view(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 2 * ONE, 255);
        send_pixel(0, 0);
        send_pixel(4095, 4095);
        send_pixel(4095, 0);
        set_view(32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 32'h7FFF_FFFF, 255);
        send_pixel(0, 0);
        send_pixel(4095, 4095);

        // one axis lands exactly on the radius
        set_view(-2 * ONE, 0, 0, 0, 2 * ONE, 255);
        send_pixel(7, 9);

        // top of the nominal radius range
        set_view(-2 * ONE, DEFAULT_IM, DEFAULT_STEP, DEFAULT_STEP, 4 * ONE, 255);
        send_pixel(1024, 1536);
        send_pixel(3000, 2000);

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            random_view(p % 6);
            calm = (p % 5 == 4);
            repeat (PHASE_REQUESTS) send_pixel(pick_index(), pick_index());
        end

        wait_idle();
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Result side back-pressure
    initial
    begin
        out_stall = 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            run_len = 1 + pick_gap();
            out_stall <= 1'b0;
            repeat (run_len) @(posedge clk);
            hold_len = pick_gap();
            if (hold_len != 0)
            begin
                out_stall <= 1'b1;
                repeat (hold_len) @(posedge clk);
            end
        end
    end

    initial
    begin
        #(120_000_000);
        $display("== FAIL ==");
        $finish;
    end

endmodule
